// ===== hw/rtl/slvs_pkg.sv =====
// Package for the staff line vertical scan unit: constants, register codes,
// configuration type, controller states and the command and status structs.
// Depends on nothing; every other RTL and bench file but slvs_if imports it.
package slvs_pkg;

  localparam int MaxWidthDef = 1024;
  localparam int MaxGapDef   = 32;
  localparam int MaxHeight   = 4096;
  localparam int RowW        = 13;
  localparam int DistW       = 7;
  localparam int RunW        = 8;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_GAP_MIN  = 3'd2,
    REG_GAP_MAX  = 3'd3,
    REG_LINE_W   = 3'd4,
    REG_RUN_LOW  = 3'd5,
    REG_RUN_HIGH = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] image_width;
    logic [12:0] image_height;
    logic [5:0]  gap_min;
    logic [5:0]  gap_max;
    logic [5:0]  line_width;
    logic [6:0]  run_low;
    logic [6:0]  run_high;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SANE, ST_CALC, ST_CMP, ST_CENT_RD, ST_CENT_CHK, ST_SRCH_RD,
    ST_SRCH_CHK, ST_RUN_RD, ST_RUN_CHK, ST_EMIT, ST_STORE
  } state_e;

  typedef struct packed {
    logic take;
    logic sanitize;
    logic calc;
    logic cent_init;
    logic probe_run;
    logic probe_issue;
    logic srch_init;
    logic srch_adv;
    logic found_set;
    logic run_inc;
    logic run_switch;
    logic emit;
    logic store;
  } cmd_t;

  typedef struct packed {
    logic ready_hit;
    logic store_ok;
    logic thin;
    logic d_done;
    logic probe_bit;
    logic k_done;
    logic run_dir;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/slvs_if.sv =====
// Request and result channel interfaces of the staff line vertical scan unit.
// Standalone; used by the top level.
interface slvs_in_if;
  logic valid;
  logic ready;
  logic op;
  logic orig_black;
  logic thin_black;
  modport source(output valid, op, orig_black, thin_black, input ready);
  modport sink(input valid, op, orig_black, thin_black, output ready);
endinterface

interface slvs_out_if;
  logic        valid;
  logic        ready;
  logic        line_mark;
  logic [11:0] pixel_row;
  logic [9:0]  pixel_col;
  logic        last;
  modport source(output valid, line_mark, pixel_row, pixel_col, last, input ready);
  modport sink(input valid, line_mark, pixel_row, pixel_col, last, output ready);
endinterface

// ===== hw/rtl/staff_line_vertical_scan_unit.sv =====
// Top level of the staff line vertical scan unit: register bank, controller
// and datapath. Depends on slvs_pkg, slvs_if, slvs_cfg, slvs_ctrl and slvs_dp.
// A request that judges a pixel also runs the probe states and waits out any output stall;
// the single read port of the row window memory, probed one pixel at a time, bounds their speed.
// One request is in flight at a time; a finished result waits in an output register.
// Reset clears positions and control state; the row window memory is not cleared.
module staff_line_vertical_scan_unit import slvs_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef,
  parameter int MAX_GAP   = MaxGapDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slvs_in_if.sink     in_if,
  slvs_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  slvs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  slvs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid),
    .in_ready_o(in_ready),
    .sts_i(sts),
    .cmd_o(cmd)
  );

  slvs_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_GAP(MAX_GAP)) u_dp (
    .clk_i, .rst_ni,
    .cfg_i(cfg),
    .cmd_i(cmd),
    .sts_o(sts),
    .op_i(in_if.op),
    .orig_black_i(in_if.orig_black),
    .thin_black_i(in_if.thin_black),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .line_mark_o(out_if.line_mark),
    .pixel_row_o(out_if.pixel_row),
    .pixel_col_o(out_if.pixel_col),
    .last_o(out_if.last)
  );

  assign in_if.ready = in_ready;

endmodule

// ===== hw/rtl/slvs_cfg.sv =====
// Configuration register bank on an APB-style port.
// Depends on slvs_pkg.
module slvs_cfg import slvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 11'd1024;
      cfg_q.image_height <= 13'd1024;
      cfg_q.gap_min      <= 6'd8;
      cfg_q.gap_max      <= 6'd13;
      cfg_q.line_width   <= 6'd2;
      cfg_q.run_low      <= 7'd1;
      cfg_q.run_high     <= 7'd5;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_WIDTH:    cfg_q.image_width  <= pwdata[10:0];
        REG_HEIGHT:   cfg_q.image_height <= pwdata[12:0];
        REG_GAP_MIN:  cfg_q.gap_min      <= pwdata[5:0];
        REG_GAP_MAX:  cfg_q.gap_max      <= pwdata[5:0];
        REG_LINE_W:   cfg_q.line_width   <= pwdata[5:0];
        REG_RUN_LOW:  cfg_q.run_low      <= pwdata[6:0];
        REG_RUN_HIGH: cfg_q.run_high     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:    prdata = {21'd0, cfg_q.image_width};
      REG_HEIGHT:   prdata = {19'd0, cfg_q.image_height};
      REG_GAP_MIN:  prdata = {26'd0, cfg_q.gap_min};
      REG_GAP_MAX:  prdata = {26'd0, cfg_q.gap_max};
      REG_LINE_W:   prdata = {26'd0, cfg_q.line_width};
      REG_RUN_LOW:  prdata = {25'd0, cfg_q.run_low};
      REG_RUN_HIGH: prdata = {25'd0, cfg_q.run_high};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/slvs_ctrl.sv =====
// Controller state machine: sequences sanitising, readiness check, the judging
// probes, result output and the store of each request. Depends on slvs_pkg.
module slvs_ctrl import slvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   second_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.take) begin
        second_q <= 1'b0;
        done_q   <= 1'b0;
      end else begin
        if (state_q == ST_STORE) second_q <= 1'b1;
        if (cmd_o.emit) done_q <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_SANE;
      ST_SANE:     state_d = ST_CALC;
      ST_CALC:     state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.ready_hit) state_d = ST_CENT_RD;
        else if (!second_q) state_d = ST_STORE;
        else state_d = ST_IDLE;
      end
      ST_CENT_RD:  state_d = ST_CENT_CHK;
      ST_CENT_CHK: state_d = sts_i.thin ? ST_SRCH_RD : ST_EMIT;
      ST_SRCH_RD:  state_d = sts_i.d_done ? ST_EMIT : ST_SRCH_CHK;
      ST_SRCH_CHK: state_d = sts_i.probe_bit ? ST_RUN_RD : ST_SRCH_RD;
      ST_RUN_RD: begin
        if (!sts_i.k_done) state_d = ST_RUN_CHK;
        else if (sts_i.run_dir) state_d = ST_EMIT;
        else state_d = ST_RUN_RD;
      end
      ST_RUN_CHK: begin
        if (sts_i.probe_bit || !sts_i.run_dir) state_d = ST_RUN_RD;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) state_d = second_q ? ST_IDLE : ST_STORE;
      end
      ST_STORE:    state_d = (sts_i.store_ok && !done_q) ? ST_CALC : ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_SANE:     cmd_o.sanitize = 1'b1;
      ST_CALC:     cmd_o.calc = 1'b1;
      ST_CMP:      cmd_o.cent_init = sts_i.ready_hit;
      ST_CENT_RD: begin
        cmd_o.probe_run   = 1'b1;
        cmd_o.probe_issue = 1'b1;
      end
      ST_CENT_CHK: cmd_o.srch_init = 1'b1;
      ST_SRCH_RD:  cmd_o.probe_issue = !sts_i.d_done;
      ST_SRCH_CHK: begin
        cmd_o.found_set = sts_i.probe_bit;
        cmd_o.srch_adv  = !sts_i.probe_bit;
      end
      ST_RUN_RD: begin
        cmd_o.probe_run   = 1'b1;
        cmd_o.probe_issue = !sts_i.k_done;
        cmd_o.run_switch  = sts_i.k_done && !sts_i.run_dir;
      end
      ST_RUN_CHK: begin
        cmd_o.run_inc    = sts_i.probe_bit;
        cmd_o.run_switch = !sts_i.probe_bit && !sts_i.run_dir;
      end
      ST_EMIT:     cmd_o.emit = !sts_i.out_busy;
      ST_STORE:    cmd_o.store = 1'b1;
      default: ;
    endcase
  end

  a_take_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == ST_SANE) else $error("request not followed by sanitise");
  a_calc_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |=> state_q == ST_CMP) else $error("compare skipped");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_busy) else $error("result overwritten");
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && done_q) |-> 1'b0) else $error("two results for one request");

endmodule

// ===== hw/rtl/slvs_dp.sv =====
// Datapath: position counters, row window memory, probe address unit, run
// counters and the output register. Depends on slvs_pkg.
module slvs_dp import slvs_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef,
  parameter int MAX_GAP   = MaxGapDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        op_i,
  input  logic        orig_black_i,
  input  logic        thin_black_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_mark_o,
  output logic [11:0] pixel_row_o,
  output logic [9:0]  pixel_col_o,
  output logic        last_o
);

  localparam int WinRows = 2 * MAX_GAP + 1;
  localparam int Depth   = WinRows * MAX_WIDTH;
  localparam int AddrW   = $clog2(Depth);
  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int WW      = ColW + 1;
  localparam int SlotW   = $clog2(WinRows);
  localparam int SW1     = SlotW + 1;
  localparam int CntW    = RowW + WW + 1;

  logic [1:0]       mem_q [Depth];
  logic [1:0]       rdata_q;
  logic             pv_q;
  logic [RowW-1:0]  in_row_q, j_row_q;
  logic [ColW-1:0]  in_col_q, j_col_q;
  logic [SlotW-1:0] in_rs_q, j_rs_q;
  logic             op_q, ob_q, tb_q, store_q;
  logic [CntW-1:0]  count_q, need_q;
  logic [DistW-1:0] d_q, k_q, dn_q, up_q;
  logic [1:0]       csel_q;
  logic             side_q, dir_q, found_q;
  logic             out_valid_q, mark_q, last_q;
  logic [11:0]      row_q;
  logic [9:0]       col_q;

  logic [31:0]      w32, h32, gmax32, lw32, addr32, jc32, ic32;
  logic [WW-1:0]    w;
  logic [RowW-1:0]  h;
  logic [DistW-1:0] gmax, lw, e;
  logic             side, row_ok, col_ok, pok, bad;
  logic [1:0]       cs;
  logic [SW1-1:0]   e_s, t_dn, t_up, rs;
  logic [ColW-1:0]  pc;
  logic [WW-1:0]    jc1, ic1;
  logic [RowW:0]    far;
  logic [RunW-1:0]  s;
  logic [AddrW-1:0] raddr, waddr;

  always_comb begin
    w32 = 32'(cfg_i.image_width);
    if (w32 == 0) w32 = 32'd1;
    else if (w32 > MAX_WIDTH) w32 = MAX_WIDTH;
    w = w32[WW-1:0];
    h32 = 32'(cfg_i.image_height);
    if (h32 == 0) h32 = 32'd1;
    else if (h32 > MaxHeight) h32 = MaxHeight;
    h = h32[RowW-1:0];
    gmax32 = 32'(cfg_i.gap_max);
    if (gmax32 > MAX_GAP + 1) gmax32 = MAX_GAP + 1;
    gmax = gmax32[DistW-1:0];
    lw32 = 32'(cfg_i.line_width);
    if (lw32 > MAX_GAP + 1) lw32 = MAX_GAP + 1;
    lw = lw32[DistW-1:0];
  end

  assign jc1 = {1'b0, j_col_q} + WW'(1);
  assign ic1 = {1'b0, in_col_q} + WW'(1);
  assign far = {1'b0, j_row_q} + (RowW + 1)'(MAX_GAP);

  assign bad = (j_row_q >= h) || ({1'b0, j_col_q} >= w) || (in_row_q > h) ||
               ({1'b0, in_col_q} >= w) || (in_row_q == h && in_col_q != '0);

  // Probe address: row offset up or down from the judged pixel, column c-1..c+1.
  always_comb begin
    e    = cmd_i.probe_run ? k_q : d_q;
    side = cmd_i.probe_run ? dir_q : side_q;
    cs   = cmd_i.probe_run ? 2'd1 : csel_q;
    e_s  = SW1'(e);
    row_ok = side ? ({{(RowW - DistW){1'b0}}, e} <= j_row_q)
                  : (({1'b0, j_row_q} + (RowW + 1)'(e)) < {1'b0, h});
    t_dn = {1'b0, j_rs_q} + e_s;
    if (t_dn >= SW1'(WinRows)) t_dn = t_dn - SW1'(WinRows);
    t_up = ({1'b0, j_rs_q} >= e_s) ? ({1'b0, j_rs_q} - e_s)
                                   : ({1'b0, j_rs_q} + SW1'(WinRows) - e_s);
    rs = side ? t_up : t_dn;
    case (cs)
      2'd0: begin
        col_ok = (j_col_q != '0);
        pc     = j_col_q - ColW'(1);
      end
      2'd2: begin
        col_ok = (jc1 < w);
        pc     = jc1[ColW-1:0];
      end
      default: begin
        col_ok = 1'b1;
        pc     = j_col_q;
      end
    endcase
    pok    = row_ok && col_ok;
    addr32 = 32'(rs) * MAX_WIDTH + 32'(pc);
    raddr  = pok ? addr32[AddrW-1:0] : '0;
  end

  assign waddr = AddrW'(32'(in_rs_q) * MAX_WIDTH + 32'(in_col_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_q) mem_q[waddr] <= {tb_q, ob_q};
    if (cmd_i.probe_issue) rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q <= op_i;
      ob_q <= orig_black_i;
      tb_q <= thin_black_i;
    end
    if (cmd_i.calc) begin
      count_q <= CntW'(in_row_q) * CntW'(w) + CntW'(in_col_q);
      if (far >= {1'b0, h}) need_q <= CntW'(h) * CntW'(w);
      else need_q <= CntW'(far) * CntW'(w) +
                     CntW'((jc1 < w) ? jc1 : (w - WW'(1))) + CntW'(1);
      store_q <= !op_q && (in_row_q < h);
    end
    if (cmd_i.srch_init) begin
      d_q    <= DistW'(cfg_i.gap_min);
      csel_q <= 2'd0;
      side_q <= 1'b0;
    end else if (cmd_i.srch_adv) begin
      if (csel_q == 2'd2) begin
        csel_q <= 2'd0;
        side_q <= !side_q;
        if (side_q) d_q <= d_q + DistW'(1);
      end else begin
        csel_q <= csel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_rs_q     <= '0;
      j_row_q     <= '0;
      j_col_q     <= '0;
      j_rs_q      <= '0;
      pv_q        <= 1'b0;
      k_q         <= '0;
      dir_q       <= 1'b0;
      dn_q        <= '0;
      up_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.probe_issue) pv_q <= pok;
      if (cmd_i.cent_init) begin
        k_q     <= '0;
        dir_q   <= 1'b0;
        dn_q    <= '0;
        up_q    <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.found_set) found_q <= 1'b1;
      if (cmd_i.run_inc) begin
        k_q <= k_q + DistW'(1);
        if (dir_q) up_q <= up_q + DistW'(1);
        else dn_q <= dn_q + DistW'(1);
      end
      if (cmd_i.run_switch) begin
        dir_q <= 1'b1;
        k_q   <= '0;
      end
      if (cmd_i.sanitize && bad) begin
        in_row_q <= '0;
        in_col_q <= '0;
        in_rs_q  <= '0;
        j_row_q  <= '0;
        j_col_q  <= '0;
        j_rs_q   <= '0;
      end
      if (cmd_i.store && store_q) begin
        if (ic1 >= w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RowW'(1);
          in_rs_q  <= (in_rs_q == SlotW'(WinRows - 1)) ? '0 : in_rs_q + SlotW'(1);
        end else begin
          in_col_q <= ic1[ColW-1:0];
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (jc1 >= w) begin
          if ((j_row_q + RowW'(1)) >= h) begin
            in_row_q <= '0;
            in_col_q <= '0;
            in_rs_q  <= '0;
            j_row_q  <= '0;
            j_col_q  <= '0;
            j_rs_q   <= '0;
          end else begin
            j_col_q <= '0;
            j_row_q <= j_row_q + RowW'(1);
            j_rs_q  <= (j_rs_q == SlotW'(WinRows - 1)) ? '0 : j_rs_q + SlotW'(1);
          end
        end else begin
          j_col_q <= jc1[ColW-1:0];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s  = RunW'(dn_q) + RunW'(up_q);
  assign jc32 = 32'(j_col_q);
  assign ic32 = 32'(in_col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mark_q <= found_q && (s != '0) && ((s - RunW'(1)) >= RunW'(cfg_i.run_low)) &&
                ((s - RunW'(1)) <= RunW'(cfg_i.run_high));
      row_q  <= j_row_q[11:0];
      col_q  <= jc32[9:0];
      last_q <= (j_row_q == h - RowW'(1)) && (jc1 == w);
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_mark_o = mark_q;
  assign pixel_row_o = row_q;
  assign pixel_col_o = col_q;
  assign last_o      = last_q;

  assign sts_o.ready_hit = count_q >= need_q;
  assign sts_o.store_ok  = store_q && (ic32 < 32'hFFFF_FFFF);
  assign sts_o.thin      = pv_q && rdata_q[1];
  assign sts_o.d_done    = d_q >= gmax;
  assign sts_o.probe_bit = pv_q && rdata_q[0];
  assign sts_o.k_done    = k_q >= lw;
  assign sts_o.run_dir   = dir_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.probe_issue && pok) |-> (32'(rs) < WinRows)) else $error("slot out of window");
  a_run_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run_inc |-> !sts_o.k_done) else $error("run count beyond cap");
  a_center_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cent_init |=> (cmd_i.probe_issue && pok)) else $error("judged pixel outside image");

endmodule

// ===== bench/staff_line_vertical_scan_unit_tb.sv =====
// Testbench for staff_line_vertical_scan_unit: a directed table, then random images
// whose judgements are checked against a behavioural predictor kept in this file.
// Depends on slvs_pkg, slvs_if and the RTL of the unit.
`timescale 1ns / 1ps

module staff_line_vertical_scan_unit_tb;
  import slvs_pkg::*;

  localparam int MAXW = MaxWidthDef;
  localparam int MAXG = MaxGapDef;
  localparam int WROWS = 2 * MAXG + 1;
  localparam int STALL_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 700;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic        mark;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } judgement_t;

  typedef struct packed {
    logic op;
    logic orig;
    logic thin;
    logic no_result;
  } stim_row_t;

  typedef struct {
    int unsigned w, h, gmin, gmax, lw, rlo, rhi, images, tx, rx;
    bit          hold;
  } setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  slvs_in_if in_ch ();
  slvs_out_if out_ch ();

  staff_line_vertical_scan_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [1:0] row_window [WROWS*MAXW];
  int unsigned reg_w, reg_h, reg_gmin, reg_gmax, reg_lw, reg_rlo, reg_rhi;
  int unsigned in_row, in_col, jdg_row, jdg_col;
  judgement_t judgement_q[$];

  int unsigned err_cnt = 0, n_req = 0, n_res = 0, n_marks = 0, idle_cnt = 0;
  int unsigned tx_pct = 0, rx_pct = 0;
  bit hold_req = 0;

  function automatic int unsigned eff_width();
    if (reg_w < 1) return 1;
    return (reg_w > MAXW) ? MAXW : reg_w;
  endfunction

  function automatic int unsigned eff_height();
    if (reg_h < 1) return 1;
    return (reg_h > MaxHeight) ? MaxHeight : reg_h;
  endfunction

  function automatic bit black_at(int r, int c, int h, int w);
    if (r < 0 || r >= h || c < 0 || c >= w) return 1'b0;
    return row_window[(r % WROWS) * MAXW + c][0];
  endfunction

  function automatic bit black_near(int r, int c, int h, int w);
    return black_at(r, c - 1, h, w) | black_at(r, c, h, w) | black_at(r, c + 1, h, w);
  endfunction

  function automatic bit staff_pixel(int r, int c, int h, int w);
    int gmax, lw, d, dn, up, run;
    bit found;
    gmax = (reg_gmax > MAXG + 1) ? MAXG + 1 : reg_gmax;
    lw = (reg_lw > MAXG + 1) ? MAXG + 1 : reg_lw;
    dn = 0;
    up = 0;
    found = 1'b0;
    if (!row_window[(r % WROWS) * MAXW + c][1]) return 1'b0;
    for (d = reg_gmin; d < gmax && !found; d++)
      found = black_near(r + d, c, h, w) | black_near(r - d, c, h, w);
    if (!found) return 1'b0;
    while (dn < lw && black_at(r + dn, c, h, w)) dn++;
    while (up < lw && black_at(r - up, c, h, w)) up++;
    run = dn + up - 1;
    return run >= int'(reg_rlo) && run <= int'(reg_rhi);
  endfunction

  function automatic bit window_full(int unsigned count, int unsigned h, int unsigned w);
    int unsigned far_row, cn, need;
    far_row = jdg_row + MAXG;
    if (far_row >= h) begin
      need = h * w;
    end else begin
      cn = (jdg_col + 1 < w) ? jdg_col + 1 : w - 1;
      need = far_row * w + cn + 1;
    end
    return count >= need;
  endfunction

  function automatic void judge_next(int unsigned h, int unsigned w);
    judgement_t j;
    j.mark = staff_pixel(jdg_row, jdg_col, h, w);
    j.row = jdg_row[11:0];
    j.col = jdg_col[9:0];
    j.last = (jdg_row == h - 1 && jdg_col == w - 1);
    judgement_q = {judgement_q, j};
    jdg_col++;
    if (jdg_col >= w) begin
      jdg_col = 0;
      jdg_row++;
    end
    if (jdg_row >= h) begin
      in_row = 0;
      in_col = 0;
      jdg_row = 0;
      jdg_col = 0;
    end
  endfunction

  function automatic void predict_request(logic op, logic orig, logic thin);
    int unsigned w, h, count;
    bit keep, done;
    w = eff_width();
    h = eff_height();
    done = 1'b0;
    if (jdg_row >= h || jdg_col >= w || in_row > h || in_col >= w ||
        (in_row == h && in_col != 0)) begin
      in_row = 0;
      in_col = 0;
      jdg_row = 0;
      jdg_col = 0;
    end
    count = in_row * w + in_col;
    keep = (op == OP_PIXEL) && (in_row < h);
    if (window_full(count, h, w)) begin
      judge_next(h, w);
      done = 1'b1;
    end
    if (keep) begin
      row_window[(in_row % WROWS) * MAXW + in_col] = {thin, orig};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      count = in_row * w + in_col;
    end
    if (!done && window_full(count, h, w)) judge_next(h, w);
  endfunction

  function automatic bit image_idle();
    return in_row == 0 && in_col == 0 && jdg_row == 0 && jdg_col == 0;
  endfunction

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:    reg_w = val & 32'h7FF;
      REG_HEIGHT:   reg_h = val & 32'h1FFF;
      REG_GAP_MIN:  reg_gmin = val & 32'h3F;
      REG_GAP_MAX:  reg_gmax = val & 32'h3F;
      REG_LINE_W:   reg_lw = val & 32'h3F;
      REG_RUN_LOW:  reg_rlo = val & 32'h7F;
      REG_RUN_HIGH: reg_rhi = val & 32'h7F;
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    wait (judgement_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_WIDTH, s.w);
    write_reg(REG_HEIGHT, s.h);
    write_reg(REG_GAP_MIN, s.gmin);
    write_reg(REG_GAP_MAX, s.gmax);
    write_reg(REG_LINE_W, s.lw);
    write_reg(REG_RUN_LOW, s.rlo);
    write_reg(REG_RUN_HIGH, s.rhi);
    tx_pct = s.tx;
    rx_pct = s.rx;
  endtask

  task automatic send_request(logic op, logic orig, logic thin);
    if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.orig_black <= orig;
    in_ch.thin_black <= thin;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_request(op, orig, thin);
    n_req++;
  endtask

  task automatic send_image();
    int unsigned r, c, w, h, spacing, thick;
    bit orig, thin;
    w = eff_width();
    h = eff_height();
    spacing = $urandom_range(3, 10);
    thick = $urandom_range(1, 2);
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if ($urandom_range(19) == 0) send_request(OP_FLUSH, 1'($urandom), 1'($urandom));
        if ((r % spacing) < thick) orig = ($urandom_range(7) != 0);
        else orig = ($urandom_range(9) == 0);
        thin = orig ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
        send_request(OP_PIXEL, orig, thin);
      end
    end
    while (!image_idle())
      send_request(($urandom_range(4) == 0) ? OP_PIXEL : OP_FLUSH, 1'($urandom),
                   1'($urandom));
  endtask

  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_FLUSH, 1'b0, 1'b0, 1'b1},
    '{OP_PIXEL, 1'b1, 1'b1, 1'b0}, '{OP_PIXEL, 1'b1, 1'b1, 1'b0},
    '{OP_PIXEL, 1'b0, 1'b0, 1'b0}, '{OP_PIXEL, 1'b1, 1'b0, 1'b0},
    '{OP_PIXEL, 1'b0, 1'b0, 1'b0}, '{OP_PIXEL, 1'b1, 1'b1, 1'b0},
    '{OP_PIXEL, 1'b0, 1'b0, 1'b0}, '{OP_PIXEL, 1'b0, 1'b0, 1'b0},
    '{OP_PIXEL, 1'b0, 1'b0, 1'b0}, '{OP_PIXEL, 1'b1, 1'b1, 1'b0},
    '{OP_PIXEL, 1'b1, 1'b0, 1'b0}, '{OP_PIXEL, 1'b0, 1'b1, 1'b0},
    '{OP_FLUSH, 1'b0, 1'b0, 1'b0}, '{OP_PIXEL, 1'b1, 1'b1, 1'b0},
    '{OP_FLUSH, 1'b1, 1'b1, 1'b0}, '{OP_FLUSH, 1'b0, 1'b0, 1'b0},
    '{OP_FLUSH, 1'b0, 1'b0, 1'b0}, '{OP_FLUSH, 1'b0, 1'b0, 1'b0},
    '{OP_FLUSH, 1'b0, 1'b0, 1'b0}, '{OP_FLUSH, 1'b0, 1'b0, 1'b0},
    '{OP_FLUSH, 1'b0, 1'b0, 1'b0}, '{OP_FLUSH, 1'b0, 1'b0, 1'b0},
    '{OP_FLUSH, 1'b0, 1'b0, 1'b0}
  };

  always @(posedge clk_i) begin
    judgement_t want;
    if (out_ch.valid && out_ch.ready) begin
      n_res++;
      if (out_ch.line_mark) n_marks++;
      if (judgement_q.size() == 0) begin
        $error("unexpected result row %0d col %0d", out_ch.pixel_row, out_ch.pixel_col);
        err_cnt++;
      end else begin
        want = judgement_q.pop_front();
        if (out_ch.line_mark !== want.mark) begin
          $error("line_mark expected %0d actual %0d", want.mark, out_ch.line_mark);
          err_cnt++;
        end
        if (out_ch.pixel_row !== want.row) begin
          $error("pixel_row expected %0d actual %0d", want.row, out_ch.pixel_row);
          err_cnt++;
        end
        if (out_ch.pixel_col !== want.col) begin
          $error("pixel_col expected %0d actual %0d", want.col, out_ch.pixel_col);
          err_cnt++;
        end
        if (out_ch.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_ch.last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  initial begin
    setting_t plan [8];
    int unsigned p, k, before_cnt;
    in_ch.valid = 1'b0;
    in_ch.op = OP_FLUSH;
    in_ch.orig_black = 1'b0;
    in_ch.thin_black = 1'b0;
    reg_w = 1024;
    reg_h = 1024;
    reg_gmin = 8;
    reg_gmax = 13;
    reg_lw = 2;
    reg_rlo = 1;
    reg_rhi = 5;
    in_row = 0;
    in_col = 0;
    jdg_row = 0;
    jdg_col = 0;
    foreach (row_window[i]) row_window[i] = '0;
    plan[0] = '{3, 4, 1, 3, 2, 1, 3, 0, 0, 0, 0};
    plan[1] = '{8, 24, 3, 6, 2, 1, 4, 1, 0, 0, 0};
    plan[2] = '{16, 12, 0, 4, 3, 0, 6, 1, 77, 0, 0};
    plan[3] = '{1, 70, 32, 33, 33, 0, 65, 1, 38, 38, 1};
    plan[4] = '{40, 0, 0, 2, 1, 0, 0, 1, 0, 77, 0};
    plan[5] = '{0, 0, 0, 1, 1, 0, 0, 3, 77, 77, 0};
    plan[6] = '{5, 10, 2, 63, 0, 0, 127, 1, 0, 0, 0};
    plan[7] = '{6, 10, 5, 5, 63, 127, 127, 1, 38, 38, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting(plan[0]);
    for (k = 0; k < N_DIRECTED; k++) begin
      before_cnt = judgement_q.size();
      send_request(DIRECTED[k].op, DIRECTED[k].orig, DIRECTED[k].thin);
      if (DIRECTED[k].no_result && judgement_q.size() != before_cnt) begin
        $error("early flush expected no result, row %0d", k);
        err_cnt++;
      end
    end
    in_ch.valid <= 1'b0;

    for (p = 1; p < 8; p++) begin
      apply_setting(plan[p]);
      hold_req = plan[p].hold;
      for (k = 0; k < plan[p].images; k++) send_image();
      in_ch.valid <= 1'b0;
    end

    wait (judgement_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests over 8 register settings, images from 1x1 to 40 wide.",
             n_req);
    $display("Checked %0d judged pixels, %0d of them staff-line marks.", n_res, n_marks);
    if (err_cnt == 0 && judgement_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/slvs_pkg.sv
hw/rtl/slvs_if.sv
hw/rtl/slvs_cfg.sv
hw/rtl/slvs_ctrl.sv
hw/rtl/slvs_dp.sv
hw/rtl/staff_line_vertical_scan_unit.sv
bench/staff_line_vertical_scan_unit_tb.sv
